// File: src/playfair_decrypt_top_defines.svh
// ----------------------------------------------------------------------------
// playfair_decrypt_top_defines.svh
// Assertion macros shared by the Playfair decrypt checker.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DECRYPT_TOP_DEFINES_SVH
`define PLAYFAIR_DECRYPT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define PF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Types, constants and helpers for the Playfair decrypt block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pf_pkg;

   localparam int GRID_SIDE  = 5;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int ALPHABET   = 26;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;

   localparam letter_type LETTER_A = 5'd0;
   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_Z = 5'd25;

   typedef enum logic [1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_KEY     = 2'd1,
      MODE_DECRYPT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_GRID,
      ST_OUT
   } state_type;

   typedef struct packed {
      coord_type row;
      coord_type col;
   } pos_type;

   typedef struct packed {
      logic       we;
      cell_type   slot;
      letter_type letter;
      pos_type    pos;
   } ram_wr_type;

   typedef struct packed {
      logic       pos_en;
      letter_type letter_a;
      letter_type letter_b;
      logic       grid_en;
      cell_type   cell_a;
      cell_type   cell_b;
   } ram_rd_type;

   // saturate to Z, then J reads as I
   function automatic letter_type fold_letter(input letter_type v);
      letter_type c;
      c = (v > LETTER_Z) ? LETTER_Z : v;
      return (c == LETTER_J) ? LETTER_I : c;
   endfunction

   function automatic cell_type cell_of(input coord_type row, input coord_type col);
      return cell_type'(int'(row) * GRID_SIDE + int'(col));
   endfunction

endpackage

// File: src/pf_key_ram.sv
// ----------------------------------------------------------------------------
// pf_key_ram
// Grid letter memory and letter position memory, two registered reads each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pf_key_ram (
   input  logic              clock,
   input  pf_pkg::ram_wr_type wr,
   input  pf_pkg::ram_rd_type rd,
   output pf_pkg::pos_type    pos_a,
   output pf_pkg::pos_type    pos_b,
   output pf_pkg::letter_type grid_a,
   output pf_pkg::letter_type grid_b
);
   import pf_pkg::*;

   letter_type grid_mem [GRID_CELLS];
   pos_type    pos_mem  [ALPHABET];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         grid_mem[wr.slot]  <= wr.letter;
         pos_mem[wr.letter] <= wr.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.pos_en) begin
         pos_a <= pos_mem[rd.letter_a];
         pos_b <= pos_mem[rd.letter_b];
      end
      if (rd.grid_en) begin
         grid_a <= grid_mem[rd.cell_a];
         grid_b <= grid_mem[rd.cell_b];
      end
   end

endmodule

// File: src/pf_placer.sv
// ----------------------------------------------------------------------------
// pf_placer
// Used-letter flags and fill pointer; decides whether a letter enters the grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pf_placer (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               place_en,
   input  pf_pkg::letter_type place_letter,
   output pf_pkg::ram_wr_type wr
);
   import pf_pkg::*;

   logic [ALPHABET-1:0] used_ff;
   logic [4:0]          count_ff, count_in;
   coord_type           row_ff, row_in;
   coord_type           col_ff, col_in;
   logic                in_range;
   logic                take;

   assign in_range = place_letter < letter_type'(ALPHABET);
   assign take = place_en && in_range && !used_ff[place_letter]
                 && (count_ff < 5'(GRID_CELLS));

   assign wr.we     = take;
   assign wr.slot   = count_ff;
   assign wr.letter = place_letter;
   assign wr.pos    = '{row: row_ff, col: col_ff};

   always_comb begin
      count_in = count_ff + 5'd1;
      if (col_ff == coord_type'(GRID_SIDE - 1)) begin
         col_in = '0;
         row_in = row_ff + 3'd1;
      end else begin
         col_in = col_ff + 3'd1;
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         used_ff  <= '0;
         count_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else if (take) begin
         used_ff[place_letter] <= 1'b1;
         count_ff <= count_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

endmodule

// File: src/pf_cell_unit.sv
// ----------------------------------------------------------------------------
// pf_cell_unit
// Digraph rule unit: row/column compare and shifted cell addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pf_cell_unit (
   input  pf_pkg::pos_type  pos_a,
   input  pf_pkg::pos_type  pos_b,
   output pf_pkg::cell_type cell_a,
   output pf_pkg::cell_type cell_b
);
   import pf_pkg::*;

   function automatic coord_type prev(input coord_type x);
      return (x == '0) ? coord_type'(GRID_SIDE - 1) : x - 3'd1;
   endfunction

   always_comb begin
      priority if (pos_a.row == pos_b.row) begin
         cell_a = cell_of(pos_a.row, prev(pos_a.col));
         cell_b = cell_of(pos_b.row, prev(pos_b.col));
      end else if (pos_a.col == pos_b.col) begin
         cell_a = cell_of(prev(pos_a.row), pos_a.col);
         cell_b = cell_of(prev(pos_b.row), pos_b.col);
      end else begin
         cell_a = cell_of(pos_a.row, pos_b.col);
         cell_b = cell_of(pos_b.row, pos_a.col);
      end
   end

endmodule

// File: src/playfair_decrypt_top.sv
// ----------------------------------------------------------------------------
// playfair_decrypt_top
// Playfair decryption over a 5x5 key grid, built by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  request | req_valid/ready, mode, letter_first/second,  | in
//          | key_end                                      |
//  result  | rsp_valid/ready, plain_first/second,         | out
//          | not_ready                                    |
//
// Clear key and a plain key letter leave the sequencer idle. A key letter with
// key_end adds an alphabet walk (one letter per cycle offered to the placer).
// A decrypt transaction reaches rsp_valid through position RAM read, then
// grid RAM read, then the output register load once that register is free. A
// decrypt before the key is complete skips both reads and goes to the load.
// Reset (synchronous) empties the key; the RAMs are not cleared.
// req_ready is high only when the sequencer is idle; a stalled result sits in
// the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module playfair_decrypt_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [4:0] req_letter_first,
   input  logic [4:0] req_letter_second,
   input  logic       req_key_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_plain_first,
   output logic [4:0] rsp_plain_second,
   output logic       rsp_not_ready
);
   import pf_pkg::*;

   state_type  state_ff, state_in;
   letter_type walk_ff, walk_in;
   logic       grid_ready_ff, grid_ready_in;
   logic       err_ff, err_in;
   logic       rsp_valid_ff, rsp_valid_in;
   letter_type plain_first_ff, plain_first_in;
   letter_type plain_second_ff, plain_second_in;
   logic       not_ready_ff, not_ready_in;

   logic       accept;
   logic       clear;
   logic       place_en;
   letter_type place_letter;
   ram_wr_type wr;
   ram_rd_type rd;
   pos_type    pos_a, pos_b;
   letter_type grid_a, grid_b;
   cell_type   cell_a, cell_b;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   pf_placer u_placer (
      .clock        (clock),
      .reset        (reset),
      .clear        (clear),
      .place_en     (place_en),
      .place_letter (place_letter),
      .wr           (wr)
   );

   pf_key_ram u_ram (
      .clock  (clock),
      .wr     (wr),
      .rd     (rd),
      .pos_a  (pos_a),
      .pos_b  (pos_b),
      .grid_a (grid_a),
      .grid_b (grid_b)
   );

   pf_cell_unit u_cell (
      .pos_a  (pos_a),
      .pos_b  (pos_b),
      .cell_a (cell_a),
      .cell_b (cell_b)
   );

   always_comb begin
      state_in        = state_ff;
      walk_in         = walk_ff;
      grid_ready_in   = grid_ready_ff;
      err_in          = err_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      plain_first_in  = plain_first_ff;
      plain_second_in = plain_second_ff;
      not_ready_in    = not_ready_ff;
      clear           = 1'b0;
      place_en        = 1'b0;
      place_letter    = (req_letter_first == LETTER_J) ? LETTER_I : req_letter_first;
      // read addresses: positions straight from the request, cells from the rule unit
      rd.letter_a     = fold_letter(req_letter_first);
      rd.letter_b     = fold_letter(req_letter_second);
      rd.cell_a       = cell_a;
      rd.cell_b       = cell_b;
      rd.pos_en       = 1'b0;
      rd.grid_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode_type'(req_mode))
                  MODE_CLEAR: begin
                     clear         = 1'b1;
                     grid_ready_in = 1'b0;
                  end
                  MODE_KEY: begin
                     // a finished grid ignores key letters until cleared
                     if (!grid_ready_ff) begin
                        place_en = 1'b1;
                        if (req_key_end) begin
                           walk_in  = LETTER_A;
                           state_in = ST_FILL;
                        end
                     end
                  end
                  MODE_DECRYPT: begin
                     if (grid_ready_ff) begin
                        rd.pos_en = 1'b1;
                        err_in    = 1'b0;
                        state_in  = ST_GRID;
                     end else begin
                        err_in   = 1'b1;
                        state_in = ST_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            // walk A..Z, J skipped; the placer drops used letters
            place_letter = walk_ff;
            place_en     = (walk_ff != LETTER_J);
            walk_in      = walk_ff + 5'd1;
            if (walk_ff == LETTER_Z) begin
               grid_ready_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_GRID: begin
            rd.grid_en = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               plain_first_in  = err_ff ? LETTER_A : grid_a;
               plain_second_in = err_ff ? LETTER_A : grid_b;
               not_ready_in    = err_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         grid_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         grid_ready_ff <= grid_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      walk_ff         <= walk_in;
      err_ff          <= err_in;
      plain_first_ff  <= plain_first_in;
      plain_second_ff <= plain_second_in;
      not_ready_ff    <= not_ready_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_plain_first  = plain_first_ff;
   assign rsp_plain_second = plain_second_ff;
   assign rsp_not_ready    = not_ready_ff;

endmodule

// File: src/pf_checker.sv
// ----------------------------------------------------------------------------
// pf_checker
// Port-level checks on the Playfair decrypt block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "playfair_decrypt_top_defines.svh"

module pf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_plain_first,
   input logic [4:0] rsp_plain_second,
   input logic       rsp_not_ready
);
   import pf_pkg::*;

   logic dec_accept;
   assign dec_accept = req_valid && req_ready && (req_mode == MODE_DECRYPT);

   `PF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_plain_first) && $stable(rsp_plain_second) && $stable(rsp_not_ready), "result changed while stalled")
   `PF_ASSERT_NOW(a_err_zero, rsp_valid && rsp_not_ready, rsp_plain_first == LETTER_A && rsp_plain_second == LETTER_A, "error result carries letters")
   `PF_ASSERT_NEXT(a_dec_busy, dec_accept, !req_ready, "decrypt did not hold off the next transaction")
   `PF_ASSERT_NOW(a_no_j, rsp_valid && !rsp_not_ready, rsp_plain_first != LETTER_J && rsp_plain_second != LETTER_J && rsp_plain_first <= LETTER_Z && rsp_plain_second <= LETTER_Z, "plaintext letter outside grid alphabet")

endmodule

bind playfair_decrypt_top pf_checker u_pf_checker (.*);

// File: tb/tb_playfair_decrypt_top.sv
// ----------------------------------------------------------------------------
// tb_playfair_decrypt_top
// Self-checking bench for the Playfair decrypt block. A behavioral key grid
// tracks every accepted request transaction and queues the plaintext pair
// each decrypt should return. Directed keys and digraphs come first, then
// randomized key sessions with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_playfair_decrypt_top;
   import pf_pkg::*;

   // mode code the block must ignore (no result, no state change)
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam letter_type LETTER_TOP  = 5'd31;

   localparam int RANDOM_ITEMS = 900;
   localparam int MAX_REPORTS  = 10;
   // covers the alphabet walk after a key_end letter, with margin
   localparam int TAIL_CYCLES  = 40;

   typedef struct packed {
      letter_type first;
      letter_type second;
      logic       not_ready;
   } plain_pair_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode          = 2'd0;
   logic [4:0] req_letter_first  = 5'd0;
   logic [4:0] req_letter_second = 5'd0;
   logic       req_key_end       = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic [4:0] rsp_plain_first;
   logic [4:0] rsp_plain_second;
   logic       rsp_not_ready;

   playfair_decrypt_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_letter_first  (req_letter_first),
      .req_letter_second (req_letter_second),
      .req_key_end       (req_key_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_plain_first   (rsp_plain_first),
      .rsp_plain_second  (rsp_plain_second),
      .rsp_not_ready     (rsp_not_ready)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Key grid shadow: letters by cell, cell by letter, used flags
   // ---------------------------------------------------------------------
   letter_type     key_grid  [GRID_CELLS];
   cell_type       key_cell  [ALPHABET];
   logic           key_taken [ALPHABET];
   int             key_fill  = 0;
   logic           key_done  = 1'b0;

   plain_pair_type expected_plain [$];
   int             error_count  = 0;
   int             useful_items = 0;
   // set for whole sessions to get back-to-back traffic on both channels
   logic           no_idle      = 1'b0;

   initial begin
      foreach (key_taken[i]) key_taken[i] = 1'b0;
   end

   function automatic int draw_wait();
      if (no_idle || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   // mostly real letters, sometimes the out-of-range codes 26..31
   function automatic letter_type draw_letter();
      if ($urandom_range(0, 9) == 0) return letter_type'($urandom_range(26, 31));
      return letter_type'($urandom_range(0, 25));
   endfunction

   function automatic letter_type letter_of(input byte c);
      return letter_type'(c - "A");
   endfunction

   function void place_key_letter(input int c);
      if (c >= ALPHABET || key_taken[c] || key_fill >= GRID_CELLS) return;
      key_grid[key_fill] = letter_type'(c);
      key_cell[c]        = cell_type'(key_fill);
      key_taken[c]       = 1'b1;
      key_fill++;
   endfunction

   // Updates the grid shadow for one accepted transaction; a decrypt queues
   // its plaintext pair.
   function void predict_request(input logic [1:0] mode, input letter_type first,
                                 input letter_type second, input logic key_end);
      letter_type     fa, fb;
      int             pa, pb, ra, ca, rb, cb, oa, ob;
      plain_pair_type pair;
      case (mode)
         MODE_CLEAR: begin
            foreach (key_taken[i]) key_taken[i] = 1'b0;
            key_fill = 0;
            key_done = 1'b0;
         end
         MODE_KEY: begin
            // a finished grid ignores key letters until the next clear
            if (!key_done) begin
               if (first <= LETTER_Z)
                  place_key_letter((first == LETTER_J) ? LETTER_I : first);
               if (key_end) begin
                  for (int c = 0; c < ALPHABET; c++)
                     if (c != LETTER_J) place_key_letter(c);
                  key_done = 1'b1;
               end
            end
         end
         MODE_DECRYPT: begin
            if (!key_done) begin
               pair.first     = '0;
               pair.second    = '0;
               pair.not_ready = 1'b1;
            end else begin
               // out-of-range codes saturate to Z, J reads as I
               fa = (first  > LETTER_Z) ? LETTER_Z : first;
               fb = (second > LETTER_Z) ? LETTER_Z : second;
               if (fa == LETTER_J) fa = LETTER_I;
               if (fb == LETTER_J) fb = LETTER_I;
               pa = int'(key_cell[fa]) % GRID_CELLS;
               pb = int'(key_cell[fb]) % GRID_CELLS;
               ra = pa / GRID_SIDE;
               ca = pa % GRID_SIDE;
               rb = pb / GRID_SIDE;
               cb = pb % GRID_SIDE;
               if (ra == rb) begin
                  // same row (and identical letters): one column left
                  oa = ra * GRID_SIDE + (ca + GRID_SIDE - 1) % GRID_SIDE;
                  ob = rb * GRID_SIDE + (cb + GRID_SIDE - 1) % GRID_SIDE;
               end else if (ca == cb) begin
                  oa = ((ra + GRID_SIDE - 1) % GRID_SIDE) * GRID_SIDE + ca;
                  ob = ((rb + GRID_SIDE - 1) % GRID_SIDE) * GRID_SIDE + cb;
               end else begin
                  oa = ra * GRID_SIDE + cb;
                  ob = rb * GRID_SIDE + ca;
               end
               pair.first     = key_grid[oa];
               pair.second    = key_grid[ob];
               pair.not_ready = 1'b0;
            end
            expected_plain.push_back(pair);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side: random gap, then hold valid and payload until accepted.
   // When the gap is zero valid simply stays high into the next transaction.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [1:0] mode, input letter_type first,
                               input letter_type second, input logic key_end);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_letter_first  <= first;
      req_letter_second <= second;
      req_key_end       <= key_end;
      do @(posedge clock); while (!req_ready);
      predict_request(mode, first, second, key_end);
      if (mode != MODE_UNUSED) useful_items++;
   endtask

   task automatic send_decrypt(input letter_type first, input letter_type second);
      send_request(MODE_DECRYPT, first, second, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_key(input letter_type letter, input logic key_end);
      send_request(MODE_KEY, letter, draw_letter(), key_end);
   endtask

   task automatic send_clear();
      send_request(MODE_CLEAR, draw_letter(), draw_letter(), 1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall a random number of cycles per transaction
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Every accepted result is matched against the oldest queued pair.
   always @(posedge clock) begin : check_plain
      plain_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_plain.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: result with none pending: first=%0d second=%0d not_ready=%0b",
                        $realtime, rsp_plain_first, rsp_plain_second, rsp_not_ready);
         end else begin
            want = expected_plain.pop_front();
            if (rsp_plain_first !== want.first || rsp_plain_second !== want.second ||
                rsp_not_ready !== want.not_ready) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: mismatch: expected %0d %0d nr=%0b, got %0d %0d nr=%0b",
                           $realtime, want.first, want.second, want.not_ready,
                           rsp_plain_first, rsp_plain_second, rsp_not_ready);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Out of reset the grid is empty: decrypts flag not_ready, mode 3 is dropped.
   task automatic test_decrypt_before_key();
      send_decrypt(LETTER_A, LETTER_Z);
      send_request(MODE_UNUSED, LETTER_TOP, LETTER_TOP, 1'b1);
      send_decrypt(LETTER_TOP, LETTER_TOP);
   endtask

   // Key made of one skipped letter with key_end: grid is the plain alphabet.
   task automatic test_empty_key();
      send_key(LETTER_TOP, 1'b1);
      send_decrypt(letter_of("A"), letter_of("E"));   // same row, wrap left
      send_decrypt(letter_of("A"), letter_of("V"));   // same column, wrap up
      send_decrypt(letter_of("B"), letter_of("K"));   // rectangle
      send_decrypt(letter_of("C"), letter_of("C"));   // identical letters
      send_decrypt(LETTER_J, LETTER_Z);               // J folds to I
      send_decrypt(LETTER_TOP, letter_of("A"));       // saturates to Z
      send_decrypt(LETTER_A, 5'd26);
      send_decrypt(LETTER_Z, LETTER_A);
      // grid already complete: key letters are dropped until a clear
      send_key(letter_of("Q"), 1'b1);
      send_decrypt(letter_of("Q"), letter_of("U"));
   endtask

   // Keyword with a J, a repeat and a skipped code, then decrypts.
   task automatic test_keyword();
      send_clear();
      send_decrypt(letter_of("M"), letter_of("P"));   // not ready after clear
      send_key(LETTER_J, 1'b0);
      send_key(letter_of("U"), 1'b0);
      send_key(letter_of("M"), 1'b0);
      send_key(letter_of("U"), 1'b0);
      send_key(5'd28, 1'b0);
      send_key(letter_of("P"), 1'b0);
      send_key(letter_of("R"), 1'b1);
      send_decrypt(letter_of("I"), letter_of("M"));
      send_decrypt(letter_of("U"), letter_of("B"));
      send_decrypt(letter_of("X"), LETTER_J);
   endtask

   // Randomized sessions: mostly clear, keyword, key_end, then a run of
   // digraphs; some noise and some keys that never finish.
   task automatic test_random_sessions();
      int start_items, pick, key_len, text_len;
      start_items = useful_items;
      while (useful_items - start_items < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         pick    = $urandom_range(0, 9);
         if (pick == 0) begin
            // raw noise over every mode and field value
            repeat ($urandom_range(2, 8))
               send_request(2'($urandom_range(0, 3)), letter_type'($urandom_range(0, 31)),
                            letter_type'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
         end else if (pick == 1) begin
            // broken session: key letters without key_end, then digraphs
            if ($urandom_range(0, 1)) send_clear();
            repeat ($urandom_range(0, 5)) send_key(draw_letter(), 1'b0);
            repeat ($urandom_range(1, 4)) send_decrypt(draw_letter(), draw_letter());
         end else begin
            key_len  = $urandom_range(0, 10);
            text_len = $urandom_range(4, 24);
            send_clear();
            for (int i = 0; i < key_len; i++)
               send_key(draw_letter(), 1'b0);
            send_key(draw_letter(), 1'b1);
            for (int i = 0; i < text_len; i++) begin
               if ($urandom_range(0, 15) == 0)
                  send_key(draw_letter(), 1'($urandom_range(0, 1)));
               send_decrypt(draw_letter(), draw_letter());
            end
         end
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_decrypt_before_key();
      test_empty_key();
      test_keyword();
      test_random_sessions();
      // this step just accepted the last transaction
      req_valid <= 1'b0;
      while (expected_plain.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
